[src/qslerp_pkg.sv]
// Shared types, constants and CORDIC arctangent table for the quaternion slerp pipeline.
package qslerp_pkg;

    localparam int FRAC_BITS = 15;
    localparam int WORK_FRAC = 30;
    localparam int STEPS     = 30;
    localparam int CW        = 35;
    localparam int WW        = 31;
    localparam int SQ_STEPS  = 31;
    localparam int DIV_STEPS = 31;
    localparam int LATENCY   = 3 + SQ_STEPS + 2 * STEPS + 1 + DIV_STEPS + 2;

    localparam logic [WW-1:0]        WORK_ONE    = WW'(1) << WORK_FRAC;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 35'sh0_26DD_3B6A;
    localparam logic [14:0]          THR_RESET   = 15'd3;

    typedef struct packed {
        logic signed [15:0] a_x;
        logic signed [15:0] a_y;
        logic signed [15:0] a_z;
        logic signed [15:0] a_w;
        logic signed [15:0] b_x;
        logic signed [15:0] b_y;
        logic signed [15:0] b_z;
        logic signed [15:0] b_w;
        logic        [15:0] blend;
    } t_in;

    typedef struct packed {
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_z;
        logic signed [15:0] out_w;
    } t_out;

    function automatic logic [31:0] atan_val(input int idx);
        logic [31:0] v;
        case (idx)
            0:       v = 32'h3243F6A8;
            1:       v = 32'h1DAC6705;
            2:       v = 32'h0FADBAFC;
            3:       v = 32'h07F56EA6;
            4:       v = 32'h03FEAB76;
            5:       v = 32'h01FFD55B;
            6:       v = 32'h00FFFAAA;
            7:       v = 32'h007FFF55;
            8:       v = 32'h003FFFEA;
            9:       v = 32'h001FFFFD;
            10:      v = 32'h000FFFFF;
            11:      v = 32'h0007FFFF;
            12:      v = 32'h0003FFFF;
            13:      v = 32'h0001FFFF;
            14:      v = 32'h0000FFFF;
            15:      v = 32'h00007FFF;
            16:      v = 32'h00003FFF;
            17:      v = 32'h00001FFF;
            18:      v = 32'h00000FFF;
            19:      v = 32'h000007FF;
            20:      v = 32'h000003FF;
            21:      v = 32'h000001FF;
            22:      v = 32'h000000FF;
            23:      v = 32'h0000007F;
            24:      v = 32'h0000003F;
            25:      v = 32'h0000001F;
            26:      v = 32'h0000000F;
            27:      v = 32'h00000008;
            28:      v = 32'h00000004;
            29:      v = 32'h00000002;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

[src/quaternion_slerp.sv]
// Quaternion slerp top level: dot product, square root, CORDIC angle and sines, divide, blend.
// Throughput: one transaction per cycle; busy is never raised.
// Depth is set by the 31-step square root, two 30-step CORDIC chains and the 31-step divider.
// Reset: synchronous active-low; clears all valid bits and loads the threshold r_thr with 3.
// The receiver cannot stall: each result is shown for one cycle only.
module quaternion_slerp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  qslerp_pkg::t_in      i_item,
    output logic                 o_valid,
    output qslerp_pkg::t_out     o_result,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [14:0]          i_cfg_data
);
    import qslerp_pkg::*;

    typedef struct packed {
        logic [3:0][15:0] qa;
        logic [3:0][16:0] qb;
        logic [WW-1:0]    t;
        logic             slerp;
        logic [WW-1:0]    c;
        logic [WW-1:0]    s;
    } t_side;

    logic        accept;
    logic [14:0] r_thr;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_thr <= i_cfg_data;
        end
    end

    // stage 1: products
    logic signed [15:0] in_a [4];
    logic signed [15:0] in_b [4];
    logic               r_v1;
    logic signed [31:0] r_p1 [4];
    t_side              r_side1;
    t_side              n_side1;

    assign in_a[0] = i_item.a_x;
    assign in_a[1] = i_item.a_y;
    assign in_a[2] = i_item.a_z;
    assign in_a[3] = i_item.a_w;
    assign in_b[0] = i_item.b_x;
    assign in_b[1] = i_item.b_y;
    assign in_b[2] = i_item.b_z;
    assign in_b[3] = i_item.b_w;

    always_comb begin
        n_side1 = '0;
        for (int j = 0; j < 4; j++) begin
            n_side1.qa[j] = in_a[j];
            n_side1.qb[j] = 17'(in_b[j]);
        end
        n_side1.t = (i_item.blend > 16'h8000) ? WORK_ONE : {i_item.blend, 15'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 4; j++) begin
            r_p1[j] <= in_a[j] * in_b[j];
        end
        r_side1 <= n_side1;
    end

    // stage 2: dot, short-arc flip, threshold test
    logic signed [33:0] dot;
    logic [33:0]        adot;
    logic signed [34:0] diff;
    logic               neg;
    logic               r_v2;
    t_side              r_side2;
    t_side              n_side2;

    always_comb begin
        dot  = 34'(r_p1[0]) + 34'(r_p1[1]) + 34'(r_p1[2]) + 34'(r_p1[3]);
        neg  = dot[33];
        adot = neg ? 34'(-dot) : 34'(dot);
        diff = 35'sh0_4000_0000 - $signed({1'b0, adot});
        n_side2 = r_side1;
        for (int j = 0; j < 4; j++) begin
            n_side2.qb[j] = neg ? 17'(-$signed(r_side1.qb[j])) : r_side1.qb[j];
        end
        n_side2.slerp = diff > $signed({5'b0, r_thr, 15'b0});
        n_side2.c     = (adot > 34'h0_4000_0000) ? WORK_ONE : adot[WW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side2 <= n_side2;
    end

    // stage 3: 1 - c^2
    logic [61:0] csq;
    logic        r_v3;
    logic [60:0] r_rem3;
    t_side       r_side3;

    assign csq = 62'(r_side2.c) * 62'(r_side2.c);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem3  <= 61'(62'h1000_0000_0000_0000 - csq);
        r_side3 <= r_side2;
    end

    // square root, one result bit per stage
    logic [60:0]   r_sq_rem  [SQ_STEPS];
    logic [WW-1:0] r_sq_root [SQ_STEPS];
    t_side         r_sq_side [SQ_STEPS];
    logic          r_sq_v    [SQ_STEPS];

    for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
        localparam int K = SQ_STEPS - 1 - i;
        logic [60:0]   rem_in;
        logic [WW-1:0] root_in;
        t_side         side_in;
        logic          v_in;
        logic [61:0]   d;
        logic          ge;

        if (i == 0) begin : g_first
            assign rem_in  = r_rem3;
            assign root_in = '0;
            assign side_in = r_side3;
            assign v_in    = r_v3;
        end else begin : g_next
            assign rem_in  = r_sq_rem[i-1];
            assign root_in = r_sq_root[i-1];
            assign side_in = r_sq_side[i-1];
            assign v_in    = r_sq_v[i-1];
        end

        assign d  = (62'(root_in) << (K + 1)) + (62'd1 << (2 * K));
        assign ge = 62'(rem_in) >= d;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[i] <= 1'b0;
            end else begin
                r_sq_v[i] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_sq_rem[i]  <= ge ? 61'(62'(rem_in) - d) : rem_in;
            r_sq_root[i] <= ge ? (root_in | (WW'(1) << K)) : root_in;
            r_sq_side[i] <= side_in;
        end
    end

    // angle: atan2(s, c)
    t_side                dl1_in;
    logic signed [CW-1:0] omega;
    t_side                r_dl1_side [STEPS];
    logic                 r_dl1_v    [STEPS];

    always_comb begin
        dl1_in   = r_sq_side[SQ_STEPS-1];
        dl1_in.s = r_sq_root[SQ_STEPS-1];
    end

    qslerp_cordic #(.VECTOR(1'b1)) u_vec (
        .i_clk (i_clk),
        .i_x   ($signed(CW'(dl1_in.c))),
        .i_y   ($signed(CW'(dl1_in.s))),
        .i_z   ('0),
        .o_res (omega)
    );

    for (genvar i = 0; i < STEPS; i++) begin : g_dl1
        if (i == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dl1_v[i] <= 1'b0;
                end else begin
                    r_dl1_v[i] <= r_sq_v[SQ_STEPS-1];
                end
            end
            always_ff @(posedge i_clk) begin
                r_dl1_side[i] <= dl1_in;
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dl1_v[i] <= 1'b0;
                end else begin
                    r_dl1_v[i] <= r_dl1_v[i-1];
                end
            end
            always_ff @(posedge i_clk) begin
                r_dl1_side[i] <= r_dl1_side[i-1];
            end
        end
    end

    // partial angles (1-t)*omega and t*omega
    t_side              ang_side;
    logic [WW-1:0]      wt;
    logic signed [66:0] r_ang_p;
    logic signed [66:0] r_ang_q;
    t_side              r_ang_side;
    logic               r_ang_v;

    assign ang_side = r_dl1_side[STEPS-1];
    assign wt       = WORK_ONE - ang_side.t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ang_v <= 1'b0;
        end else begin
            r_ang_v <= r_dl1_v[STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_ang_p    <= $signed({1'b0, wt}) * omega;
        r_ang_q    <= $signed({1'b0, ang_side.t}) * omega;
        r_ang_side <= ang_side;
    end

    // sines of both partial angles
    logic signed [CW-1:0] sin_p;
    logic signed [CW-1:0] sin_q;
    t_side                r_dl2_side [STEPS];
    logic                 r_dl2_v    [STEPS];

    qslerp_cordic #(.VECTOR(1'b0)) u_sin_p (
        .i_clk (i_clk),
        .i_x   (CORDIC_GAIN),
        .i_y   ('0),
        .i_z   (r_ang_p[CW+WORK_FRAC-1:WORK_FRAC]),
        .o_res (sin_p)
    );

    qslerp_cordic #(.VECTOR(1'b0)) u_sin_q (
        .i_clk (i_clk),
        .i_x   (CORDIC_GAIN),
        .i_y   ('0),
        .i_z   (r_ang_q[CW+WORK_FRAC-1:WORK_FRAC]),
        .o_res (sin_q)
    );

    for (genvar i = 0; i < STEPS; i++) begin : g_dl2
        if (i == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dl2_v[i] <= 1'b0;
                end else begin
                    r_dl2_v[i] <= r_ang_v;
                end
            end
            always_ff @(posedge i_clk) begin
                r_dl2_side[i] <= r_ang_side;
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dl2_v[i] <= 1'b0;
                end else begin
                    r_dl2_v[i] <= r_dl2_v[i-1];
                end
            end
            always_ff @(posedge i_clk) begin
                r_dl2_side[i] <= r_dl2_side[i-1];
            end
        end
    end

    // divide each sine by s, one quotient bit per stage, two lanes
    logic signed [CW-1:0] dv_y [2];
    logic [32:0]          r_dv_rem  [DIV_STEPS][2];
    logic [WW-1:0]        r_dv_q    [DIV_STEPS][2];
    logic                 r_dv_zero [DIV_STEPS][2];
    logic                 r_dv_ovf  [DIV_STEPS][2];
    t_side                r_dv_side [DIV_STEPS];
    logic                 r_dv_v    [DIV_STEPS];

    assign dv_y[0] = sin_p;
    assign dv_y[1] = sin_q;

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
        localparam int K = DIV_STEPS - 1 - i;
        t_side side_in;
        logic  v_in;

        if (i == 0) begin : g_first
            assign side_in = r_dl2_side[STEPS-1];
            assign v_in    = r_dl2_v[STEPS-1];
        end else begin : g_next
            assign side_in = r_dv_side[i-1];
            assign v_in    = r_dv_v[i-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[i] <= 1'b0;
            end else begin
                r_dv_v[i] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_dv_side[i] <= side_in;
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [32:0]   rem_in;
            logic [WW-1:0] q_in;
            logic          zero_in;
            logic          ovf_in;
            logic          ge;

            if (i == 0) begin : g_first
                assign rem_in  = {1'b0, dv_y[l][31:0]};
                assign q_in    = '0;
                assign zero_in = dv_y[l] <= 0;
                assign ovf_in  = dv_y[l] >= $signed({3'b0, side_in.s, 1'b0});
            end else begin : g_next
                assign rem_in  = {r_dv_rem[i-1][l][31:0], 1'b0};
                assign q_in    = r_dv_q[i-1][l];
                assign zero_in = r_dv_zero[i-1][l];
                assign ovf_in  = r_dv_ovf[i-1][l];
            end

            assign ge = rem_in >= 33'(side_in.s);

            always_ff @(posedge i_clk) begin
                r_dv_rem[i][l]  <= ge ? rem_in - 33'(side_in.s) : rem_in;
                r_dv_q[i][l]    <= ge ? (q_in | (WW'(1) << K)) : q_in;
                r_dv_zero[i][l] <= zero_in;
                r_dv_ovf[i][l]  <= ovf_in;
            end
        end
    end

    // weight select and component products
    t_side              fin_side;
    logic [WW-1:0]      wdiv [2];
    logic [WW-1:0]      wp;
    logic [WW-1:0]      wq;
    logic               use_slerp;
    logic signed [47:0] r_mp [4];
    logic signed [48:0] r_mq [4];
    logic               r_vm;

    assign fin_side = r_dv_side[DIV_STEPS-1];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            if (r_dv_zero[DIV_STEPS-1][l]) begin
                wdiv[l] = '0;
            end else if (r_dv_ovf[DIV_STEPS-1][l] || r_dv_q[DIV_STEPS-1][l] > WORK_ONE) begin
                wdiv[l] = WORK_ONE;
            end else begin
                wdiv[l] = r_dv_q[DIV_STEPS-1][l];
            end
        end
        use_slerp = fin_side.slerp && (fin_side.s != '0);
        wp = use_slerp ? wdiv[0] : WORK_ONE - fin_side.t;
        wq = use_slerp ? wdiv[1] : fin_side.t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
        end else begin
            r_vm <= r_dv_v[DIV_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 4; j++) begin
            r_mp[j] <= $signed({1'b0, wp}) * $signed(fin_side.qa[j]);
            r_mq[j] <= $signed({1'b0, wq}) * $signed(fin_side.qb[j]);
        end
    end

    // sum, round, saturate
    logic signed [49:0] sum  [4];
    logic signed [19:0] shr  [4];
    logic signed [15:0] comp [4];
    logic               r_vo;
    t_out               r_out;

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            sum[j] = 50'(r_mp[j]) + 50'(r_mq[j]) + 50'sh2000_0000;
            shr[j] = sum[j][49:WORK_FRAC];
            if (shr[j] > 20'sd32767) begin
                comp[j] = 16'sh7FFF;
            end else if (shr[j] < -20'sd32768) begin
                comp[j] = 16'sh8000;
            end else begin
                comp[j] = shr[j][15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else begin
            r_vo <= r_vm;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.out_x <= comp[0];
        r_out.out_y <= comp[1];
        r_out.out_z <= comp[2];
        r_out.out_w <= comp[3];
    end

    assign o_valid  = r_vo;
    assign o_result = r_out;

endmodule

[src/qslerp_cordic.sv]
// Pipelined CORDIC, one iteration per register stage, vectoring or rotation mode.
module qslerp_cordic #(
    parameter bit VECTOR = 1'b0
) (
    input  logic                               i_clk,
    input  logic signed [qslerp_pkg::CW-1:0]   i_x,
    input  logic signed [qslerp_pkg::CW-1:0]   i_y,
    input  logic signed [qslerp_pkg::CW-1:0]   i_z,
    output logic signed [qslerp_pkg::CW-1:0]   o_res
);
    import qslerp_pkg::*;

    logic signed [CW-1:0] r_x [STEPS];
    logic signed [CW-1:0] r_y [STEPS];
    logic signed [CW-1:0] r_z [STEPS];

    for (genvar i = 0; i < STEPS; i++) begin : g_stage
        logic signed [CW-1:0] x_in, y_in, z_in, xs, ys, at;
        logic signed [CW-1:0] n_x, n_y, n_z;
        logic                 pos;

        if (i == 0) begin : g_first
            assign x_in = i_x;
            assign y_in = i_y;
            assign z_in = i_z;
        end else begin : g_next
            assign x_in = r_x[i-1];
            assign y_in = r_y[i-1];
            assign z_in = r_z[i-1];
        end

        assign xs  = x_in >>> i;
        assign ys  = y_in >>> i;
        assign at  = $signed(CW'(atan_val(i)));
        assign pos = VECTOR ? !(y_in > 0) : (z_in >= 0);
        assign n_x = pos ? x_in - ys : x_in + ys;
        assign n_y = pos ? y_in + xs : y_in - xs;
        assign n_z = pos ? z_in - at : z_in + at;

        always_ff @(posedge i_clk) begin
            r_x[i] <= n_x;
            r_y[i] <= n_y;
            r_z[i] <= n_z;
        end
    end

    assign o_res = VECTOR ? r_z[STEPS-1] : r_y[STEPS-1];

endmodule

[src/qslerp_chk.sv]
// Port-level checker for quaternion_slerp, bound to the top level.
module qslerp_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input qslerp_pkg::t_in      i_item,
    input logic                 o_valid,
    input qslerp_pkg::t_out     o_result,
    input logic                 i_cfg_valid,
    input logic                 o_cfg_ready,
    input logic [14:0]          i_cfg_data
);
    import qslerp_pkg::*;

    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("transaction lost");

    a_out_from_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result without transaction");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("config write refused");

endmodule

bind quaternion_slerp qslerp_chk u_qslerp_chk (.*);

[sim/quaternion_slerp_check.sv]
// Checker for the quaternion slerp block: watches transactions, predicts results, compares them.
module quaternion_slerp_check
    import qslerp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  t_in         i_item,
    input  logic        o_valid,
    input  t_out        o_result,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [14:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ONE = longint'(1) << 30;

    longint arc_tab [30] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
        64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
        64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
        64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002
    };

    logic [14:0] near_thr;
    t_out        blend_queue[$];
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = blend_queue.size();

    function automatic longint fl_shift(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > v) bit_v >>= 2;
        while (bit_v != 0) begin
            if (v >= res + bit_v) begin
                v -= res + bit_v;
                res = (res >> 1) + bit_v;
            end else begin
                res >>= 1;
            end
            bit_v >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint vec_angle(longint y, longint x);
        longint z, xs, ys;
        z = 0;
        for (int i = 0; i < 30; i++) begin
            xs = fl_shift(x, i);
            ys = fl_shift(y, i);
            if (y > 0) begin
                x = x + ys; y = y - xs; z += arc_tab[i];
            end else begin
                x = x - ys; y = y + xs; z -= arc_tab[i];
            end
        end
        return z;
    endfunction

    function automatic longint rot_sine(longint z);
        longint x, y, xs, ys;
        x = 64'h26DD3B6A;
        y = 0;
        for (int i = 0; i < 30; i++) begin
            xs = fl_shift(x, i);
            ys = fl_shift(y, i);
            if (z >= 0) begin
                x = x - ys; y = y + xs; z -= arc_tab[i];
            end else begin
                x = x + ys; y = y - xs; z += arc_tab[i];
            end
        end
        return y;
    endfunction

    function automatic longint clamp_w(longint w);
        if (w < 0) return 0;
        return (w > ONE) ? ONE : w;
    endfunction

    function automatic t_out slerp_predict(t_in q, logic [14:0] thr);
        longint qa[4], qb[4], dot, t, wp, wq, c, s, om, ap, aq, v;
        t_out r;
        qa = '{q.a_x, q.a_y, q.a_z, q.a_w};
        qb = '{q.b_x, q.b_y, q.b_z, q.b_w};
        dot = 0;
        for (int j = 0; j < 4; j++) dot += qa[j] * qb[j];
        if (dot < 0) begin
            dot = -dot;
            for (int j = 0; j < 4; j++) qb[j] = -qb[j];
        end
        t = longint'(q.blend) << 15;
        if (t > ONE) t = ONE;
        wp = ONE - t;
        wq = t;
        if (ONE - dot > (longint'(thr) << 15)) begin
            c = (dot > ONE) ? ONE : dot;
            s = int_sqrt(longint'(64'd1 << 60) - c * c);
            if (s > 0) begin
                om = vec_angle(s, c);
                ap = fl_shift((ONE - t) * om, 30);
                aq = fl_shift(t * om, 30);
                wp = clamp_w((rot_sine(ap) * ONE) / s);
                wq = clamp_w((rot_sine(aq) * ONE) / s);
            end
        end
        for (int j = 0; j < 4; j++) begin
            v = fl_shift(wp * qa[j] + wq * qb[j] + (longint'(1) << 29), 30);
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            case (j)
                0: r.out_x = v[15:0];
                1: r.out_y = v[15:0];
                2: r.out_z = v[15:0];
                default: r.out_w = v[15:0];
            endcase
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            near_thr <= THR_RESET;
            fails = 0;
            blend_queue.delete();
        end else begin
            if (o_valid) begin
                if (blend_queue.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result %h", o_result);
                end else begin
                    want = blend_queue.pop_front();
                    if (want.out_x !== o_result.out_x || want.out_y !== o_result.out_y ||
                        want.out_z !== o_result.out_z || want.out_w !== o_result.out_w) begin
                        fails++;
                        if (fails <= 10)
                            $display("result: expected x%0d y%0d z%0d w%0d, got x%0d y%0d z%0d w%0d",
                                want.out_x, want.out_y, want.out_z, want.out_w,
                                o_result.out_x, o_result.out_y, o_result.out_z,
                                o_result.out_w);
                    end
                end
            end
            if (start && !busy)
                blend_queue.push_back(slerp_predict(i_item, near_thr));
            if (i_cfg_valid && o_cfg_ready)
                near_thr <= i_cfg_data;
        end
    end
endmodule

[sim/quaternion_slerp_test.sv]
// Testbench top for the quaternion slerp block: stimulus, configuration phases and verdict.
module quaternion_slerp_test;
    timeunit 1ns;
    timeprecision 1ps;
    import qslerp_pkg::*;

    localparam int WATCH_LIMIT = 20 * LATENCY + 2000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    t_in         i_item = '0;
    logic        o_valid;
    t_out        o_result;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [14:0] i_cfg_data = '0;
    int          fail_count, pending, idle_cycles;

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    quaternion_slerp uut (.*);

    quaternion_slerp_check checker_i (
        .i_clk, .i_rst_n, .start, .busy, .i_item, .o_valid, .o_result,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("quaternion_slerp: mismatch");
            $finish;
        end
    end

    function automatic logic signed [15:0] rand_comp(int mode);
        case (mode)
            0: return 16'(32'($urandom));
            1: return 16'sd0 + $signed(16'($urandom_range(0, 16'h7FFF)));
            default: return 16'($urandom_range(0, 32) - 16) + 16'h8000;
        endcase
    endfunction

    function automatic logic [15:0] rand_blend();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'h8000;
            2: return 16'($urandom);
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    // random quaternion pair with b equal to +-a plus a perturbation of up to +-2^14
    function automatic t_in rand_pair();
        t_in q;
        int spread;
        logic neg;
        q.a_x = 16'($urandom_range(0, 46000) - 23000);
        q.a_y = 16'($urandom_range(0, 46000) - 23000);
        q.a_z = 16'($urandom_range(0, 36000) - 18000);
        q.a_w = 16'($urandom_range(0, 36000) - 18000);
        spread = 1 << $urandom_range(0, 15);
        neg = 1'($urandom_range(0, 1));
        q.b_x = 16'((neg ? -int'(q.a_x) : int'(q.a_x)) + $urandom_range(0, spread) - spread / 2);
        q.b_y = 16'((neg ? -int'(q.a_y) : int'(q.a_y)) + $urandom_range(0, spread) - spread / 2);
        q.b_z = 16'((neg ? -int'(q.a_z) : int'(q.a_z)) + $urandom_range(0, spread) - spread / 2);
        q.b_w = 16'((neg ? -int'(q.a_w) : int'(q.a_w)) + $urandom_range(0, spread) - spread / 2);
        q.blend = rand_blend();
        return q;
    endfunction

    task automatic send_item(t_in q);
        i_item <= q;
        start  <= 1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic pause_sender();
        start <= 0;
        repeat ($urandom_range(1, 12)) @(negedge i_clk);
    endtask

    task automatic write_thr(logic [14:0] v);
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
        i_cfg_data  <= v;
        i_cfg_valid <= 1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    task automatic random_phase(int n);
        int burst;
        t_in q;
        while (n > 0) begin
            burst = $urandom_range(1, 30);
            while (burst > 0 && n > 0) begin
                if ($urandom_range(0, 4) == 0) begin
                    q.a_x = rand_comp($urandom_range(0, 2));
                    q.a_y = rand_comp($urandom_range(0, 2));
                    q.a_z = rand_comp($urandom_range(0, 2));
                    q.a_w = rand_comp($urandom_range(0, 2));
                    q.b_x = rand_comp($urandom_range(0, 2));
                    q.b_y = rand_comp($urandom_range(0, 2));
                    q.b_z = rand_comp($urandom_range(0, 2));
                    q.b_w = rand_comp($urandom_range(0, 2));
                    q.blend = rand_blend();
                end else begin
                    q = rand_pair();
                end
                send_item(q);
                burst--;
                n--;
            end
            if ($urandom_range(0, 3) != 0) pause_sender();
        end
        start <= 0;
    endtask

    initial begin
        t_in q;
        logic [14:0] thr_list[5];
        thr_list = '{15'd0, 15'h7FFF, 15'd3, 15'd40, 15'd1000};
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        q = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
              16'h7FFF, 16'h4000};
        send_item(q);
        q = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
              16'h8000, 16'h8000};
        send_item(q);
        q = '{16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'h0000,
              16'h0000, 16'h2000};
        send_item(q);
        q = '{16'h5A82, 16'h0000, 16'h0000, 16'h5A82, 16'h0000, 16'h0000, 16'h5A82,
              16'h5A82, 16'h4000};
        send_item(q);
        q = '{16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h0000,
              16'h0000, 16'hFFFF};
        send_item(q);
        q = '{16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000,
              16'h0000, 16'h0000};
        send_item(q);
        q = '{16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h7FFE, 16'h0100, 16'h0000,
              16'h0000, 16'h6000};
        send_item(q);
        q = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
              16'h0000, 16'h4000};
        send_item(q);
        q = '{16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h8001, 16'h0000, 16'h0000,
              16'h0000, 16'h8000};
        send_item(q);
        start <= 0;

        foreach (thr_list[k]) begin
            write_thr(thr_list[k]);
            q = '{16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h7FF0, 16'h0400, 16'h0000,
                  16'h0000, 16'h4000};
            send_item(q);
            random_phase(240);
        end

        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
        if (fail_count == 0)
            $display("quaternion_slerp: match");
        else
            $display("quaternion_slerp: mismatch");
        $finish;
    end
endmodule

[sim.f]
src/qslerp_pkg.sv
src/qslerp_cordic.sv
src/quaternion_slerp.sv
src/qslerp_chk.sv
sim/quaternion_slerp_check.sv
sim/quaternion_slerp_test.sv
